// ===== hw/rtl/afifo_pkg.sv =====
package afifo_pkg;

  // One stored frame: sample_1 in the high word, sample_0 in the low word.
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned FRAME_W  = 2 * SAMPLE_W;
  localparam int unsigned COUNT_W  = 64;
  localparam int unsigned FREE_W   = 11;
  localparam int unsigned UNDER_W  = 32;

  // Channel count value that selects mono; every other value is stereo.
  localparam logic [1:0] CHAN_MONO  = 2'd1;
  localparam logic [1:0] CHAN_RESET = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_PULL  = 2'd1,
    OP_FLUSH = 2'd2,
    OP_PAUSE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_RESULT = 2'b10
  } state_e;

  // Flags captured when an item is taken, consumed when its result is built.
  typedef struct packed {
    logic from_fifo;
    logic accepted;
  } res_flags_t;

endpackage

// ===== hw/rtl/afifo_store.sv =====
module afifo_store
  import afifo_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  logic [FRAME_W-1:0] wr_data_i,
  input  logic               rd_en_i,
  input  logic [AW-1:0]      rd_addr_i,
  output logic [FRAME_W-1:0] rd_data_o
);

  logic [FRAME_W-1:0] mem [DEPTH];
  logic [FRAME_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/audio_frame_fifo_with_flush.sv =====
// Each input transfer updates the counters and reads the frame store; the result is then built
// into the output register once that register is free.
// No new item is taken until the result of the previous one has been loaded into the output register.
// Reset (rst_ni low, asynchronous): counts, drop point, pause and underrun count clear,
// channel count returns to 2; frame store contents are not cleared.
module audio_frame_fifo_with_flush
  import afifo_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration: channel_count
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_data_i,
  // Input items
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,  // sample_0[31:0], sample_1[63:32], pause_flag[64], zeros
  input  logic [1:0]   s_axis_tuser,  // opcode[1:0]
  // Results
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [239:0] m_axis_tdata,  // out_sample_0[31:0], out_sample_1[63:32],
                                      // free_space[74:64], play_position[138:75],
                                      // written_total[202:139], underrun_count[234:203], zeros
  output logic [1:0]   m_axis_tuser   // frame_from_fifo[0], write_accepted[1]
);

  localparam int unsigned AW = $clog2(FIFO_DEPTH);
  localparam logic [AW-1:0]      LAST_SLOT = AW'(FIFO_DEPTH - 1);
  localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(FIFO_DEPTH);
  localparam logic [FREE_W-1:0]  DEPTH_LOW = FREE_W'(FIFO_DEPTH);

  // Control and counter state
  state_e               state_q, state_d;
  logic [1:0]           chan_q;
  logic [COUNT_W-1:0]   write_q, write_d;
  logic [COUNT_W-1:0]   read_q, read_d;
  logic [COUNT_W-1:0]   drop_q, drop_d;
  logic [AW-1:0]        wr_slot_q, wr_slot_d;
  logic [AW-1:0]        rd_slot_q, rd_slot_d;
  logic [AW-1:0]        drop_slot_q, drop_slot_d;
  logic                 drop_pending_q, drop_pending_d;
  logic                 paused_q, paused_d;
  logic [UNDER_W-1:0]   under_q, under_d;
  logic                 out_valid_q, out_valid_d;

  // Payload registers
  res_flags_t           res_q, res_d;
  logic [239:0]         out_data_q;
  logic [1:0]           out_user_q;

  // Input unpacking
  op_e                  op;
  logic [SAMPLE_W-1:0]  in_s0, in_s1;
  logic                 in_pause;
  logic                 in_xfer;
  logic                 mono;

  // Pull path
  logic                 drop_now;
  logic [COUNT_W-1:0]   rd_eff;
  logic [AW-1:0]        rd_slot_eff;
  logic                 have_frame;
  logic                 not_full;

  // Frame store ports
  logic                 st_wr_en, st_rd_en;
  logic [FRAME_W-1:0]   st_wr_data, st_rd_data;

  // Result build
  logic                 res_load;
  logic [SAMPLE_W-1:0]  res_s0, res_s1;
  logic [FREE_W-1:0]    res_free;
  logic [COUNT_W-1:0]   res_pos;

  assign op       = op_e'(s_axis_tuser);
  assign in_s0    = s_axis_tdata[31:0];
  assign in_s1    = s_axis_tdata[63:32];
  assign in_pause = s_axis_tdata[64];
  assign mono     = (chan_q == CHAN_MONO);

  // Take one item at a time; the output register lets the next item in
  // while the previous result still waits for the sink.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // A pending flush is applied before the pull looks at the FIFO; the read
  // count never moves backwards.
  assign drop_now    = drop_pending_q && (read_q < drop_q);
  assign rd_eff      = drop_now ? drop_q : read_q;
  assign rd_slot_eff = drop_now ? drop_slot_q : rd_slot_q;
  assign have_frame  = !paused_q && (write_q > rd_eff);
  assign not_full    = (write_q - read_q) < DEPTH_CNT;

  // Each item touches the store once, so a write and a read of the same
  // entry never meet in one cycle: no forwarding path is needed.
  assign st_wr_en   = in_xfer && (op == OP_WRITE) && not_full;
  assign st_wr_data = {(mono ? '0 : in_s1), in_s0};
  assign st_rd_en   = in_xfer && (op == OP_PULL);

  afifo_store #(
    .DEPTH (FIFO_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (st_wr_en),
    .wr_addr_i (wr_slot_q),
    .wr_data_i (st_wr_data),
    .rd_en_i   (st_rd_en),
    .rd_addr_i (rd_slot_eff),
    .rd_data_o (st_rd_data)
  );

  // Counter and flag updates on each input transfer
  always_comb begin
    write_d        = write_q;
    read_d         = read_q;
    drop_d         = drop_q;
    wr_slot_d      = wr_slot_q;
    rd_slot_d      = rd_slot_q;
    drop_slot_d    = drop_slot_q;
    drop_pending_d = drop_pending_q;
    paused_d       = paused_q;
    under_d        = under_q;
    res_d          = res_q;
    if (in_xfer) begin
      res_d = '0;
      case (op)
        OP_WRITE: begin
          if (not_full) begin
            write_d        = write_q + COUNT_W'(1);
            wr_slot_d      = (wr_slot_q == LAST_SLOT) ? '0 : wr_slot_q + AW'(1);
            res_d.accepted = 1'b1;
          end
        end
        OP_PULL: begin
          drop_pending_d = 1'b0;
          read_d         = rd_eff;
          rd_slot_d      = rd_slot_eff;
          if (have_frame) begin
            read_d          = rd_eff + COUNT_W'(1);
            rd_slot_d       = (rd_slot_eff == LAST_SLOT) ? '0 : rd_slot_eff + AW'(1);
            res_d.from_fifo = 1'b1;
          end else if (!paused_q && (write_q != '0) && (under_q != '1)) begin
            // Count an underrun only once anything was ever written; saturate.
            under_d = under_q + UNDER_W'(1);
          end
        end
        OP_FLUSH: begin
          drop_d         = write_q;
          drop_slot_d    = wr_slot_q;
          drop_pending_d = 1'b1;
        end
        OP_PAUSE: begin
          paused_d = in_pause;
        end
        default: begin
          paused_d = paused_q;
        end
      endcase
    end
  end

  // Sequencer: advance to the result cycle after each transfer, hold there
  // until the output register is free.
  assign res_load = (state_q == ST_RESULT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (res_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Result fields come from the updated state; free space only needs the
  // low bits of the fill level.
  assign res_s0   = res_q.from_fifo ? st_rd_data[SAMPLE_W-1:0] : '0;
  assign res_s1   = (res_q.from_fifo && !mono) ? st_rd_data[FRAME_W-1:SAMPLE_W] : '0;
  assign res_free = DEPTH_LOW - (write_q[FREE_W-1:0] - read_q[FREE_W-1:0]);
  assign res_pos  = (read_q > drop_q) ? read_q : drop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      chan_q         <= CHAN_RESET;
      write_q        <= '0;
      read_q         <= '0;
      drop_q         <= '0;
      wr_slot_q      <= '0;
      rd_slot_q      <= '0;
      drop_slot_q    <= '0;
      drop_pending_q <= 1'b0;
      paused_q       <= 1'b0;
      under_q        <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      write_q        <= write_d;
      read_q         <= read_d;
      drop_q         <= drop_d;
      wr_slot_q      <= wr_slot_d;
      rd_slot_q      <= rd_slot_d;
      drop_slot_q    <= drop_slot_d;
      drop_pending_q <= drop_pending_d;
      paused_q       <= paused_d;
      under_q        <= under_d;
      out_valid_q    <= out_valid_d;
      if (cfg_valid_i) begin
        chan_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (res_load) begin
      out_data_q <= {5'b0, under_q, write_q, res_pos, res_free, res_s1, res_s0};
      out_user_q <= {res_q.accepted, res_q.from_fifo};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // The FIFO never holds more frames than it has room for.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (write_q - read_q) <= DEPTH_CNT)
    else $error("fill level exceeds FIFO depth");

  // A pull always retires any pending flush.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (op == OP_PULL)) |=> !drop_pending_q)
    else $error("flush still pending after pull");

  // Every input transfer is followed by its result cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_RESULT))
    else $error("no result cycle after transfer");

  // The underrun count never goes down.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (under_q >= $past(under_q)))
    else $error("underrun count decreased");

  // A stalled result is not overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !res_load)
    else $error("result register overwritten while stalled");

endmodule

// ===== verif/tb_audio_frame_fifo_with_flush.sv =====
`timescale 1ns / 1ps

module tb_audio_frame_fifo_with_flush;
  import afifo_pkg::*;

  localparam int unsigned DEPTH       = 1024;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned GAP_PCT     = 7;

  // One result as the sink sees it, unpacked from tdata and tuser.
  typedef struct packed {
    logic [SAMPLE_W-1:0] s0;
    logic [SAMPLE_W-1:0] s1;
    logic                from_fifo;
    logic                accepted;
    logic [FREE_W-1:0]   free;
    logic [COUNT_W-1:0]  pos;
    logic [COUNT_W-1:0]  wtotal;
    logic [UNDER_W-1:0]  under;
  } status_t;

  logic         clk_i;
  logic         rst_ni        = 1'b0;
  logic         cfg_valid_i   = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_data_i    = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata  = '0;  // sample_0[31:0], sample_1[63:32], pause_flag[64], zeros
  logic [1:0]   s_axis_tuser  = '0;  // opcode[1:0]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [239:0] m_axis_tdata;        // out_sample_0[31:0], out_sample_1[63:32],
                                     // free_space[74:64], play_position[138:75],
                                     // written_total[202:139], underrun_count[234:203], zeros
  logic [1:0]   m_axis_tuser;        // frame_from_fifo[0], write_accepted[1]

  audio_frame_fifo_with_flush #(
    .FIFO_DEPTH(DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Mirror of the playback FIFO state, advanced once per accepted input transfer.
  logic [FRAME_W-1:0] mirror_store [DEPTH];
  logic [COUNT_W-1:0] mirror_wr         = '0;
  logic [COUNT_W-1:0] mirror_rd         = '0;
  logic [COUNT_W-1:0] mirror_drop_at    = '0;
  logic               mirror_drop_armed = 1'b0;
  logic               mirror_paused     = 1'b0;
  logic [UNDER_W-1:0] mirror_underruns  = '0;
  logic [1:0]         mirror_chans      = CHAN_RESET;

  // Status reports owed by the block, oldest first.
  status_t status_due [$];

  // Run bookkeeping.
  int unsigned n_items    = 0;
  int unsigned n_refused  = 0;
  int unsigned n_flushes  = 0;
  int unsigned n_cfg      = 0;
  int unsigned n_results  = 0;
  int unsigned n_mismatch = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned hold_left  = 0;
  bit          hold_req   = 1'b0;
  bit          no_gaps    = 1'b0;

  status_t got_status;
  status_t want_status;

  //--------------------------------------------------------------------------
  // Clock and run limit
  //--------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Stop a hung run: a correct run finishes far below this count.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports still owed", cycle_cnt,
               status_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  //--------------------------------------------------------------------------
  // Predictor: apply one operation to the mirror and return the status the
  // block must report for it.
  //--------------------------------------------------------------------------
  function automatic status_t fifo_status_after(op_e op, logic [31:0] a, logic [31:0] b,
                                                logic pf);
    status_t            r;
    logic               mono;
    logic [FRAME_W-1:0] word;
    logic [COUNT_W-1:0] room;
    r    = '0;
    mono = (mirror_chans == CHAN_MONO);
    case (op)
      OP_WRITE: begin
        // Refuse the frame once DEPTH frames are held; mono stores a zero high word.
        if (mirror_wr - mirror_rd < COUNT_W'(DEPTH)) begin
          mirror_store[mirror_wr % DEPTH] = {(mono ? 32'd0 : b), a};
          mirror_wr++;
          r.accepted = 1'b1;
        end
      end
      OP_PULL: begin
        // Apply a pending flush first, even when paused; never move backwards.
        if (mirror_drop_armed) begin
          mirror_drop_armed = 1'b0;
          if (mirror_rd < mirror_drop_at) mirror_rd = mirror_drop_at;
        end
        if (!mirror_paused) begin
          if (mirror_wr > mirror_rd) begin
            word        = mirror_store[mirror_rd % DEPTH];
            r.s0        = word[31:0];
            r.s1        = mono ? 32'd0 : word[63:32];
            r.from_fifo = 1'b1;
            mirror_rd++;
          end else if (mirror_wr != '0 && mirror_underruns != '1) begin
            // Count silence only after something was ever written; saturate.
            mirror_underruns++;
          end
        end
      end
      OP_FLUSH: begin
        mirror_drop_at    = mirror_wr;
        mirror_drop_armed = 1'b1;
      end
      default: mirror_paused = pf;
    endcase
    room     = COUNT_W'(DEPTH) - (mirror_wr - mirror_rd);
    r.free   = room[FREE_W-1:0];
    r.pos    = (mirror_rd > mirror_drop_at) ? mirror_rd : mirror_drop_at;
    r.wtotal = mirror_wr;
    r.under  = mirror_underruns;
    return r;
  endfunction

  //--------------------------------------------------------------------------
  // Sink side: stall at random, or hold off for a long stretch on request.
  //--------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
      end
    end
  end

  // Compare every result transfer with the oldest owed report.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      got_status.s0        = m_axis_tdata[31:0];
      got_status.s1        = m_axis_tdata[63:32];
      got_status.free      = m_axis_tdata[74:64];
      got_status.pos       = m_axis_tdata[138:75];
      got_status.wtotal    = m_axis_tdata[202:139];
      got_status.under     = m_axis_tdata[234:203];
      got_status.from_fifo = m_axis_tuser[0];
      got_status.accepted  = m_axis_tuser[1];
      if (status_due.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("result %0d arrived with no report owed", n_results);
      end else begin
        want_status = status_due.pop_front();
        if (got_status !== want_status) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("result %0d exp/got: s0 %h/%h s1 %h/%h fifo %b/%b acc %b/%b",
                     n_results, want_status.s0, got_status.s0, want_status.s1,
                     got_status.s1, want_status.from_fifo, got_status.from_fifo,
                     want_status.accepted, got_status.accepted);
            $display("  free %0d/%0d pos %0d/%0d written %0d/%0d underruns %0d/%0d",
                     want_status.free, got_status.free, want_status.pos, got_status.pos,
                     want_status.wtotal, got_status.wtotal, want_status.under,
                     got_status.under);
          end
        end
      end
    end
  end

  //--------------------------------------------------------------------------
  // Shared driving tasks
  //--------------------------------------------------------------------------

  // Offer one item and hold it until the transfer; leave tvalid high afterwards
  // so back-to-back items never lower and raise it in the same step.
  task automatic send_op(input op_e op, input logic [31:0] a, input logic [31:0] b,
                         input logic pf);
    status_t st;
    while (!no_gaps && $urandom_range(99) < GAP_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, pf, b, a};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    st = fifo_status_after(op, a, b, pf);
    status_due.push_back(st);
    n_items++;
    if (op == OP_WRITE && !st.accepted) n_refused++;
    if (op == OP_FLUSH) n_flushes++;
  endtask

  // Drop tvalid after the last item of a phase.
  task automatic stop_input();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait out every owed report, then let the clock run on for the given tail.
  task automatic wait_idle(input int unsigned tail);
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  // Write channel_count; call only while the block is idle.
  task automatic write_channels(input logic [1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mirror_chans = value;
    n_cfg++;
    @(posedge clk_i);
  endtask

  // Any op with fully random payload, including the pause flag.
  task automatic send_random(input op_e op);
    send_op(op, $urandom, $urandom, 1'($urandom_range(1)));
  endtask

  //--------------------------------------------------------------------------
  // Tests
  //--------------------------------------------------------------------------

  // Pull before any write: silence, no underrun, also while paused.
  task automatic test_quiet_start();
    send_random(OP_PULL);
    send_op(OP_PAUSE, $urandom, $urandom, 1'b1);
    send_random(OP_PULL);
    send_op(OP_PAUSE, $urandom, $urandom, 1'b0);
  endtask

  // Extreme sample words round trip, then one empty pull counts an underrun.
  task automatic test_sample_extremes();
    send_op(OP_WRITE, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_op(OP_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_op(OP_WRITE, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    send_op(OP_WRITE, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
    repeat (5) send_random(OP_PULL);
  endtask

  // Repeated flushes keep the latest drop point; frames after it survive.
  // A flush pending while paused is still applied by the next pull.
  task automatic test_flush_points();
    send_random(OP_WRITE);
    send_random(OP_WRITE);
    send_random(OP_FLUSH);
    send_random(OP_WRITE);
    send_random(OP_FLUSH);
    send_random(OP_WRITE);
    send_random(OP_PULL);
    send_random(OP_PULL);
    send_random(OP_WRITE);
    send_random(OP_FLUSH);
    send_op(OP_PAUSE, $urandom, $urandom, 1'b1);
    send_random(OP_PULL);
    send_op(OP_PAUSE, $urandom, $urandom, 1'b0);
    stop_input();
    wait_idle(4);
  endtask

  // Mono zeroes the high word on store and on output; 0 and 3 act as stereo.
  task automatic test_channel_modes();
    write_channels(2'd1);
    send_random(OP_WRITE);
    send_random(OP_WRITE);
    send_random(OP_PULL);
    stop_input();
    wait_idle(4);
    write_channels(2'd3);
    send_random(OP_PULL);
    send_random(OP_WRITE);
    stop_input();
    wait_idle(4);
    write_channels(2'd1);
    send_random(OP_PULL);
    send_random(OP_WRITE);
    stop_input();
    wait_idle(4);
    write_channels(2'd0);
    send_random(OP_WRITE);
    send_random(OP_PULL);
    send_random(OP_PULL);
    stop_input();
    wait_idle(4);
    write_channels(CHAN_RESET);
  endtask

  // Fill to DEPTH frames with no idling on either side, push past full, then
  // free one slot and finally drop everything with a flush.
  task automatic test_fill_to_full();
    no_gaps = 1'b1;
    send_op(OP_PAUSE, $urandom, $urandom, 1'b0);
    while (mirror_wr - mirror_rd < COUNT_W'(DEPTH)) send_random(OP_WRITE);
    repeat (4) send_random(OP_WRITE);
    send_random(OP_PULL);
    send_random(OP_WRITE);
    send_random(OP_WRITE);
    send_random(OP_FLUSH);
    send_random(OP_PULL);
    send_random(OP_PULL);
    no_gaps = 1'b0;
    stop_input();
    wait_idle(4);
  endtask

  // Hold the sink off while items keep coming, so the block backs up and
  // stalls its input.
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (25) send_random(($urandom_range(1) == 0) ? OP_WRITE : OP_PULL);
    stop_input();
    wait_idle(4);
  endtask

  // Bursts of writes and pulls in shifting balance, with occasional flush and
  // pause, and a channel setting change between some bursts.
  task automatic test_random_traffic(input int unsigned target);
    int unsigned sent;
    int unsigned burst;
    int unsigned mode;
    int unsigned pick;
    int unsigned w_pct;
    int unsigned p_pct;
    op_e         op;
    sent = 0;
    while (sent < target) begin
      burst = $urandom_range(60, 15);
      mode  = $urandom_range(2);
      // write-heavy, pull-heavy or balanced
      w_pct = (mode == 0) ? 70 : (mode == 1) ? 20 : 44;
      p_pct = (mode == 0) ? 22 : (mode == 1) ? 72 : 44;
      repeat (burst) begin
        pick = $urandom_range(99);
        if (pick < w_pct) op = OP_WRITE;
        else if (pick < w_pct + p_pct) op = OP_PULL;
        else if (pick < w_pct + p_pct + 4) op = OP_FLUSH;
        else op = OP_PAUSE;
        // Resume more often than pause so playback is not stuck silent.
        if (op == OP_PAUSE) send_op(op, $urandom, $urandom, 1'($urandom_range(99) < 35));
        else send_random(op);
      end
      sent += burst;
      if ($urandom_range(3) == 0) begin
        stop_input();
        wait_idle(4);
        write_channels(2'($urandom_range(3)));
      end
    end
    stop_input();
    wait_idle(4);
  endtask

  //--------------------------------------------------------------------------
  // Sequence
  //--------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_quiet_start();
    test_sample_extremes();
    test_flush_points();
    test_channel_modes();
    test_fill_to_full();
    test_backpressure();
    test_random_traffic(30);
    write_channels(2'd1);
    test_backpressure();

    wait_idle(10);
    $display("run covered %0d items, %0d results, %0d writes refused full, %0d flushes",
             n_items, n_results, n_refused, n_flushes);
    $display("channel_count written %0d times, final underrun count %0d",
             n_cfg, mirror_underruns);
    if (n_mismatch == 0 && status_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d reports never arrived", n_mismatch, status_due.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== audio_frame_fifo_with_flush.f =====
hw/rtl/afifo_pkg.sv
hw/rtl/afifo_store.sv
hw/rtl/audio_frame_fifo_with_flush.sv
verif/tb_audio_frame_fifo_with_flush.sv
